// ----- hdl/radial_lens_distortion_point_core_macros.svh -----
// Assertion macros shared by the radial lens distortion point core.
`ifndef RADIAL_LENS_DISTORTION_POINT_CORE_MACROS_SVH
`define RADIAL_LENS_DISTORTION_POINT_CORE_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define RLD_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define RLD_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/rld_pkg.sv -----
// Package with constants, types and arithmetic helpers of the distortion core.
`timescale 1ns / 1ps
package rld_pkg;

    localparam int DEF_MAX_COEFFS = 4;
    localparam int DEF_MAX_ITERS  = 16;
    localparam int NUM_K          = 4;
    localparam int KIDX_W         = 2;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [2:0] REG_NUM_COEFFS = 3'd0;
    localparam logic [2:0] REG_K1         = 3'd1;
    localparam logic [2:0] REG_K2         = 3'd2;
    localparam logic [2:0] REG_K3         = 3'd3;
    localparam logic [2:0] REG_K4         = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SAT    = 2'd1;
    localparam logic [1:0] ST_NOCONV = 2'd2;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [2:0]  NUM_COEFFS_RST = 3'd2;
    localparam logic signed [17:0] R_LIMIT = 18'sd65536;
    localparam logic signed [18:0] STOP_TOL = 19'sd2;
    // floor(R/3) == (R * 43691) >> 17 for every 16-bit R.
    localparam logic [15:0] THIRD_RECIP = 16'd43691;
    localparam int          THIRD_SHIFT = 17;

    typedef struct packed {
        logic start;
        logic op;
        logic two_dig;
    } t_mdu_cmd;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Round to nearest, ties away from zero, then shift right by s.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int s);
        logic [63:0] m;
        m = abs64(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Clamp to 16 bits signed; the top bit of the result flags saturation.
    function automatic logic [16:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return {1'b1, 16'h7FFF};
        end
        if (v < -64'sd32768) begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, v[15:0]};
    endfunction

endpackage

// ----- hdl/rld_muldiv.sv -----
// Shared multi-cycle multiply and divide unit of the distortion core.
`timescale 1ns / 1ps
module rld_muldiv import rld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mdu_cmd    i_cmd,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);

    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic             r_op;
    logic             r_first;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_acc;

    logic [15:0]        w_dig;
    logic signed [16:0] w_sdig;
    logic signed [80:0] w_prod;
    logic [64:0]        w_shift;
    logic [65:0]        w_trial;
    logic [63:0]        n_acc;
    logic [63:0]        n_b;

    // Multiply: a times b, 16 bits of b per cycle, top digit first and signed.
    assign w_dig  = r_cnt[0] ? r_b[31:16] : r_b[15:0];
    assign w_sdig = $signed({r_first & w_dig[15], w_dig});
    assign w_prod = $signed(r_a) * w_sdig;

    // Divide: unsigned restoring, one quotient bit per cycle.
    assign w_shift = {r_acc, r_b[63]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_a};

    always_comb begin
        if (r_op == OP_MUL) begin
            n_acc = (r_acc << 16) + w_prod[63:0];
            n_b   = r_b;
        end else if (!w_trial[65]) begin
            n_acc = w_trial[63:0];
            n_b   = {r_b[62:0], 1'b1};
        end else begin
            n_acc = w_shift[63:0];
            n_b   = {r_b[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_cmd.op;
            r_acc   <= '0;
            r_first <= 1'b1;
            if (i_cmd.op == OP_DIV) begin
                // A divide computes a / b: the divisor sits in r_a and the
                // dividend shifts through r_b, which collects the quotient.
                r_a   <= i_b;
                r_b   <= i_a;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end else begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_cnt <= CNT_W'(i_cmd.two_dig);
            end
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_acc   <= n_acc;
            r_b     <= n_b;
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_DIV) ? r_b : r_acc;

endmodule

// ----- hdl/radial_lens_distortion_point_core.sv -----
// Top level of the radial lens distortion point core: registers, sequencer, handshakes.
// Forward mode's run time per point is set by the multiplies of the factor.
// Inverse mode's run time is set by the divider and the polynomial multiplies in the shared
// unit, and grows with each secant step.
// One point is in flight at a time; the finished beat waits in an output register.
// Reset (synchronous, active low) idles the sequencer, empties the output and loads the
// register defaults: two coefficients in use, all coefficients zero.
`timescale 1ns / 1ps
`include "radial_lens_distortion_point_core_macros.svh"
module radial_lens_distortion_point_core import rld_pkg::*; #(
    parameter int MAX_COEFFS = DEF_MAX_COEFFS,
    parameter int MAX_ITERS  = DEF_MAX_ITERS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic signed [15:0]  i_x_in,
    input  logic signed [15:0]  i_y_in,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_x_out,
    output logic signed [15:0]  o_y_out,
    output logic [1:0]          o_status,
    // Register port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // Only the first min(MAX_COEFFS, NUM_K) coefficients can ever be active.
    localparam int NK     = (MAX_COEFFS < NUM_K) ? MAX_COEFFS : NUM_K;
    localparam int KI_W   = $clog2(NK + 1);
    localparam int STEP_W = $clog2(MAX_ITERS + 1);

    // Sequencer states.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SQX     = 5'd1;
    localparam logic [4:0] S_SQY     = 5'd2;
    localparam logic [4:0] S_FPREP   = 5'd3;
    localparam logic [4:0] S_FTERM   = 5'd4;
    localparam logic [4:0] S_FPOW    = 5'd5;
    localparam logic [4:0] S_FWDX    = 5'd6;
    localparam logic [4:0] S_FWDY    = 5'd7;
    localparam logic [4:0] S_ROOT    = 5'd8;
    localparam logic [4:0] S_ROOTFIX = 5'd9;
    localparam logic [4:0] S_INIT    = 5'd10;
    localparam logic [4:0] S_DSQ     = 5'd11;
    localparam logic [4:0] S_DMUL    = 5'd12;
    localparam logic [4:0] S_CHECK   = 5'd13;
    localparam logic [4:0] S_SNUM    = 5'd14;
    localparam logic [4:0] S_SDIV    = 5'd15;
    localparam logic [4:0] S_SCX     = 5'd16;
    localparam logic [4:0] S_DVX     = 5'd17;
    localparam logic [4:0] S_SCY     = 5'd18;
    localparam logic [4:0] S_DVY     = 5'd19;
    localparam logic [4:0] S_DONE    = 5'd20;

    // Configuration registers.
    logic [2:0]         r_num_coeffs;
    logic signed [15:0] r_coeff [NUM_K];

    // Control state.
    logic [4:0]        r_state,     n_state;
    logic              r_wait,      n_wait;
    logic              r_out_valid, n_out_valid;
    logic [STEP_W-1:0] r_steps,     n_steps;
    logic              r_noconv,    n_noconv;
    logic              r_sat,       n_sat;
    logic [KI_W-1:0]   r_ki,        n_ki;
    logic [3:0]        r_bit,       n_bit;
    logic              r_phase,     n_phase;

    // Working values.
    logic              r_mode,  n_mode;
    logic signed [15:0] r_x,    n_x;
    logic signed [15:0] r_y,    n_y;
    logic [32:0]       r_r2,    n_r2;
    logic [20:0]       r_p1,    n_p1;
    logic [32:0]       r_pw,    n_pw;
    logic signed [47:0] r_f,    n_f;
    logic [15:0]       r_s,     n_s;
    logic [15:0]       r_bigr,  n_bigr;
    logic signed [17:0] r_rarg, n_rarg;
    logic signed [17:0] r_r0,   n_r0;
    logic signed [17:0] r_r1,   n_r1;
    logic signed [41:0] r_dr0,  n_dr0;
    logic signed [41:0] r_dr1,  n_dr1;
    logic signed [42:0] r_den,  n_den;
    logic signed [63:0] r_num,  n_num;
    logic signed [33:0] r_prod, n_prod;
    logic signed [15:0] r_xo,   n_xo;
    logic signed [15:0] r_yo,   n_yo;
    logic signed [15:0] r_ox,   n_ox;
    logic signed [15:0] r_oy,   n_oy;
    logic [1:0]        r_ost,   n_ost;

    // Shared unit hookup.
    t_mdu_cmd    w_cmd;
    logic [63:0] w_opa;
    logic [63:0] w_opb;
    logic [63:0] w_mres;
    logic        w_mdu_done;
    logic        w_take;

    // Helpers derived from the unit result and the working registers.
    logic [KI_W-1:0]    w_nact;
    logic signed [15:0] w_kcur;
    logic signed [63:0] w_rs4;
    logic signed [63:0] w_rs24;
    logic [16:0]        w_sat24;
    logic [15:0]        w_t;
    logic [31:0]        w_third;
    logic signed [18:0] w_diff;
    logic signed [63:0] w_dr64;
    logic signed [63:0] w_den64;
    logic signed [63:0] w_qs_sec;
    logic signed [63:0] w_rn64;
    logic signed [17:0] w_rn;
    logic signed [63:0] w_qs_sc;
    logic [16:0]        w_sat_sc;
    logic [63:0]        w_pmag;
    logic               w_cfg_wr;

    rld_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_mdu_done),
        .o_res   (w_mres)
    );

    // A unit result is consumed in the state that asked for it.
    assign w_take = r_wait & w_mdu_done;

    // Coefficient count, clamped to what the build can use.
    assign w_nact = (r_num_coeffs > 3'(NK)) ? KI_W'(NK) : KI_W'(r_num_coeffs);
    assign w_kcur = r_coeff[KIDX_W'(r_ki)];

    assign w_rs4   = round_shift($signed(w_mres), 4);
    assign w_rs24  = round_shift($signed(w_mres), 24);
    assign w_sat24 = sat16(w_rs24);

    // Square root: trial bit on top of the bits found so far.
    assign w_t     = r_s | (16'd1 << r_bit);
    assign w_third = r_bigr * THIRD_RECIP;

    // Secant bookkeeping.
    assign w_diff   = 19'(r_r1) - 19'(r_r0);
    assign w_dr64   = $signed({48'd0, r_bigr}) - w_rs24;
    assign w_den64  = w_dr64 - 64'(r_dr0);
    // The quotient is truncated toward zero, so its sign is applied afterwards.
    assign w_qs_sec = (r_num[63] ^ r_den[42]) ? -$signed(w_mres) : $signed(w_mres);
    assign w_rn64   = 64'(r_r1) - w_qs_sec;

    always_comb begin
        if (w_rn64 > 64'(R_LIMIT)) begin
            w_rn = R_LIMIT;
        end else if (w_rn64 < -64'(R_LIMIT)) begin
            w_rn = -R_LIMIT;
        end else begin
            w_rn = w_rn64[17:0];
        end
    end

    // Output scaling by r1/R: rounded quotient of magnitudes, sign restored.
    assign w_pmag   = abs64(64'(r_prod));
    assign w_qs_sc  = r_prod[33] ? -$signed(w_mres) : $signed(w_mres);
    assign w_sat_sc = sat16(w_qs_sc);

    // Sequencer. Each arithmetic state issues one command to the shared unit, then waits for
    // its result; most then move on, while S_ROOT repeats for each root bit.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_steps     = r_steps;
        n_noconv    = r_noconv;
        n_sat       = r_sat;
        n_ki        = r_ki;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_x         = r_x;
        n_y         = r_y;
        n_r2        = r_r2;
        n_p1        = r_p1;
        n_pw        = r_pw;
        n_f         = r_f;
        n_s         = r_s;
        n_bigr      = r_bigr;
        n_rarg      = r_rarg;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_dr0       = r_dr0;
        n_dr1       = r_dr1;
        n_den       = r_den;
        n_num       = r_num;
        n_prod      = r_prod;
        n_xo        = r_xo;
        n_yo        = r_yo;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ost       = r_ost;
        w_cmd       = '0;
        w_opa       = '0;
        w_opb       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_x      = i_x_in;
                    n_y      = i_y_in;
                    n_steps  = '0;
                    n_noconv = 1'b0;
                    n_sat    = 1'b0;
                    n_state  = S_SQX;
                end
            end
            S_SQX: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_x);
                w_opb       = 64'(r_x);
                if (w_take) begin
                    n_r2    = w_mres[32:0];
                    n_state = S_SQY;
                end
            end
            S_SQY: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_y);
                w_opb       = 64'(r_y);
                if (w_take) begin
                    n_r2    = r_r2 + w_mres[32:0];
                    n_s     = '0;
                    n_bit   = 4'd15;
                    n_state = r_mode ? S_ROOT : S_FPREP;
                end
            end
            S_FPREP: begin
                n_p1 = 21'((r_r2 + 33'd2048) >> 12);
                n_pw = 33'((r_r2 + 33'd2048) >> 12);
                n_f  = 48'sd1 <<< 24;
                n_ki = '0;
                if (w_nact == '0) begin
                    n_state = r_mode ? S_DMUL : S_FWDX;
                end else begin
                    n_state = S_FTERM;
                end
            end
            S_FTERM: begin
                w_cmd.start = !r_wait;
                w_opa       = {31'd0, r_pw};
                w_opb       = 64'(w_kcur);
                if (w_take) begin
                    n_f  = r_f + 48'(w_rs4);
                    n_ki = r_ki + 1'b1;
                    if (r_ki + 1'b1 == w_nact) begin
                        n_state = r_mode ? S_DMUL : S_FWDX;
                    end else begin
                        n_state = S_FPOW;
                    end
                end
            end
            S_FPOW: begin
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = {31'd0, r_pw};
                w_opb         = {43'd0, r_p1};
                if (w_take) begin
                    n_pw    = 33'((w_mres + 64'd32768) >> 16);
                    n_state = S_FTERM;
                end
            end
            S_FWDX: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_f);
                w_opb       = 64'(r_x);
                if (w_take) begin
                    n_xo    = w_sat24[15:0];
                    n_sat   = r_sat | w_sat24[16];
                    n_state = S_FWDY;
                end
            end
            S_FWDY: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_f);
                w_opb       = 64'(r_y);
                if (w_take) begin
                    n_yo    = w_sat24[15:0];
                    n_sat   = r_sat | w_sat24[16];
                    n_state = S_DONE;
                end
            end
            S_ROOT: begin
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = {48'd0, w_t};
                w_opb         = {48'd0, w_t};
                if (w_take) begin
                    if (w_mres <= {31'd0, r_r2}) begin
                        n_s = w_t;
                    end
                    n_bit = r_bit - 1'b1;
                    if (r_bit == 4'd0) begin
                        n_state = S_ROOTFIX;
                    end
                end
            end
            S_ROOTFIX: begin
                // Round the floor root up when r2 lies past the midpoint.
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = {48'd0, r_s};
                w_opb         = {48'd0, r_s};
                if (w_take) begin
                    if (({31'd0, r_r2} - w_mres) > {48'd0, r_s}) begin
                        n_bigr = r_s + 1'b1;
                    end else begin
                        n_bigr = r_s;
                    end
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (r_bigr == '0) begin
                    n_xo    = '0;
                    n_yo    = '0;
                    n_state = S_DONE;
                end else begin
                    n_r0    = $signed({2'b00, r_bigr >> 1});
                    n_r1    = $signed(18'(w_third >> THIRD_SHIFT));
                    n_rarg  = $signed({2'b00, r_bigr >> 1});
                    n_phase = 1'b0;
                    n_state = S_DSQ;
                end
            end
            S_DSQ: begin
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = 64'(r_rarg);
                w_opb         = 64'(r_rarg);
                if (w_take) begin
                    n_r2    = w_mres[32:0];
                    n_state = S_FPREP;
                end
            end
            S_DMUL: begin
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = 64'(r_f);
                w_opb         = 64'(r_rarg);
                if (w_take) begin
                    if (!r_phase) begin
                        n_dr0   = 42'(w_dr64);
                        n_state = S_CHECK;
                    end else begin
                        n_dr1 = 42'(w_dr64);
                        n_den = 43'(w_den64);
                        if (w_den64 == '0) begin
                            n_noconv = 1'b1;
                            n_state  = S_SCX;
                        end else begin
                            n_state = S_SNUM;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (w_diff <= STOP_TOL && w_diff >= -STOP_TOL) begin
                    n_state = S_SCX;
                end else if (r_steps == STEP_W'(MAX_ITERS)) begin
                    n_noconv = 1'b1;
                    n_state  = S_SCX;
                end else begin
                    n_rarg  = r_r1;
                    n_phase = 1'b1;
                    n_state = S_DSQ;
                end
            end
            S_SNUM: begin
                w_cmd.start   = !r_wait;
                w_cmd.two_dig = 1'b1;
                w_opa         = 64'(r_dr1);
                w_opb         = 64'(w_diff);
                if (w_take) begin
                    n_num   = $signed(w_mres);
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                w_cmd.start = !r_wait;
                w_cmd.op    = OP_DIV;
                w_opa       = abs64(r_num);
                w_opb       = abs64(64'(r_den));
                if (w_take) begin
                    n_r0    = r_r1;
                    n_r1    = w_rn;
                    n_dr0   = r_dr1;
                    n_steps = r_steps + 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_SCX: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_r1);
                w_opb       = 64'(r_x);
                if (w_take) begin
                    n_prod  = 34'($signed(w_mres));
                    n_state = S_DVX;
                end
            end
            S_DVX: begin
                w_cmd.start = !r_wait;
                w_cmd.op    = OP_DIV;
                w_opa       = (w_pmag << 1) + {48'd0, r_bigr};
                w_opb       = {47'd0, r_bigr, 1'b0};
                if (w_take) begin
                    n_xo    = w_sat_sc[15:0];
                    n_sat   = r_sat | w_sat_sc[16];
                    n_state = S_SCY;
                end
            end
            S_SCY: begin
                w_cmd.start = !r_wait;
                w_opa       = 64'(r_r1);
                w_opb       = 64'(r_y);
                if (w_take) begin
                    n_prod  = 34'($signed(w_mres));
                    n_state = S_DVY;
                end
            end
            S_DVY: begin
                w_cmd.start = !r_wait;
                w_cmd.op    = OP_DIV;
                w_opa       = (w_pmag << 1) + {48'd0, r_bigr};
                w_opb       = {47'd0, r_bigr, 1'b0};
                if (w_take) begin
                    n_yo    = w_sat_sc[15:0];
                    n_sat   = r_sat | w_sat_sc[16];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the beat over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_ox        = r_xo;
                    n_oy        = r_yo;
                    n_ost       = r_noconv ? ST_NOCONV : (r_sat ? ST_SAT : ST_OK);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_wait = r_wait;
        if (w_cmd.start) begin
            n_wait = 1'b1;
        end else if (w_take) begin
            n_wait = 1'b0;
        end
    end

    // Register port: writes take effect on the access cycle.
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_NUM_COEFFS: prdata = {29'd0, r_num_coeffs};
            REG_K1:         prdata = DATA_W'(r_coeff[0]);
            REG_K2:         prdata = DATA_W'(r_coeff[1]);
            REG_K3:         prdata = DATA_W'(r_coeff[2]);
            REG_K4:         prdata = DATA_W'(r_coeff[3]);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coeffs <= NUM_COEFFS_RST;
            for (int i = 0; i < NUM_K; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_NUM_COEFFS: r_num_coeffs <= pwdata[2:0];
                REG_K1:         r_coeff[0]   <= pwdata[15:0];
                REG_K2:         r_coeff[1]   <= pwdata[15:0];
                REG_K3:         r_coeff[2]   <= pwdata[15:0];
                REG_K4:         r_coeff[3]   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_noconv    <= 1'b0;
            r_sat       <= 1'b0;
            r_ki        <= '0;
            r_bit       <= '0;
            r_phase     <= 1'b0;
            r_r1        <= '0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
            r_noconv    <= n_noconv;
            r_sat       <= n_sat;
            r_ki        <= n_ki;
            r_bit       <= n_bit;
            r_phase     <= n_phase;
            r_r1        <= n_r1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_x    <= n_x;
        r_y    <= n_y;
        r_r2   <= n_r2;
        r_p1   <= n_p1;
        r_pw   <= n_pw;
        r_f    <= n_f;
        r_s    <= n_s;
        r_bigr <= n_bigr;
        r_rarg <= n_rarg;
        r_r0   <= n_r0;
        r_dr0  <= n_dr0;
        r_dr1  <= n_dr1;
        r_den  <= n_den;
        r_num  <= n_num;
        r_prod <= n_prod;
        r_xo   <= n_xo;
        r_yo   <= n_yo;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_ost  <= n_ost;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_ox;
    assign o_y_out     = r_oy;
    assign o_status    = r_ost;

    // An accepted point always starts the sequencer.
    `RLD_ASSERT_NXT(a_accept_starts, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted beat did not start work")
    // The secant step count never passes its limit.
    `RLD_ASSERT_IMP(a_steps_bounded, 1'b1, r_steps <= MAX_ITERS, "secant step count out of range")
    // The shared unit only reports results that were asked for.
    `RLD_ASSERT_IMP(a_result_expected, w_mdu_done, r_wait, "unit result arrived unasked")
    // The secant guess stays clamped.
    `RLD_ASSERT_IMP(a_guess_clamped, 1'b1, r_r1 <= R_LIMIT && r_r1 >= -R_LIMIT, "secant guess out of range")

endmodule
